// ===== rtl/bs3_pkg.sv =====
// Shared types and constants for the 3x3 box stencil.
package bs3_pkg;

  localparam int COEF_W   = 18;               // signed Q1.16 weight
  localparam int COEF_ROW_W = 3 * COEF_W;     // three packed weights per row
  localparam int FRAME_W  = 11;               // frame_width / frame_height
  localparam int MARGIN_W = 9;                // border_margin
  localparam int ADDR_W   = 6;                // 8-byte register slots
  localparam int DATA_W   = 64;
  localparam int FRAC_W   = 16;               // product fraction bits dropped

  typedef enum logic [2:0] {
    REG_COEF_TOP    = 3'd0,
    REG_COEF_MID    = 3'd1,
    REG_COEF_BOTTOM = 3'd2,
    REG_FRAME_WIDTH = 3'd3,
    REG_FRAME_HEIGHT = 3'd4,
    REG_MARGIN      = 3'd5
  } reg_idx_t;

  localparam logic [COEF_ROW_W-1:0] COEF_TOP_RST    = '0;
  localparam logic [COEF_ROW_W-1:0] COEF_MID_RST    = COEF_ROW_W'(65536);
  localparam logic [COEF_ROW_W-1:0] COEF_BOTTOM_RST = '0;
  localparam logic [FRAME_W-1:0]    FRAME_WIDTH_RST  = FRAME_W'(1024);
  localparam logic [FRAME_W-1:0]    FRAME_HEIGHT_RST = FRAME_W'(1024);
  localparam logic [MARGIN_W-1:0]   MARGIN_RST       = MARGIN_W'(1);

  // weight slot inside a row register for left, centre, right column
  localparam int SLOT_LEFT   = 1;
  localparam int SLOT_CENTRE = 0;
  localparam int SLOT_RIGHT  = 2;

endpackage

// ===== rtl/box_stencil_3x3.sv =====
// Nine-point 3x3 box stencil over a raster-order sample stream.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  input    | in_valid / in_ready        | in_sample, in_frame_start
//  result   | out_valid / out_ready      | out_stencil_value, out_row, out_col,
//           |                            | out_frame_end, out_saturated
//  config   | psel/penable/pwrite/pready | paddr, pwdata, prdata (64-bit regs)
//
// One word accepted per cycle while the output slot is not stalled. Between an input
// word and its result lie the line store read, multiply, two adder levels and saturate.
// Line stores are two RAMs, one read and one write port each; no clearing pass.
// A stalled result freezes the whole pipe; in_ready follows the output slot.
module box_stencil_3x3 #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int SAMPLE_BITS = 32,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  input  logic                                in_frame_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_stencil_value,
  output logic [ROW_W-1:0]                    out_row,
  output logic [COL_W-1:0]                    out_col,
  output logic                                out_frame_end,
  output logic                                out_saturated,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bs3_pkg::ADDR_W-1:0]          paddr,
  input  logic [bs3_pkg::DATA_W-1:0]          pwdata,
  output logic [bs3_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  localparam int SB       = SAMPLE_BITS;
  localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int FRAME_MAX = (1 << bs3_pkg::FRAME_W) - 1;
  localparam int DIM_TOP  = ((MAX_DIM > FRAME_MAX) ? MAX_DIM : FRAME_MAX)
                            + (1 << bs3_pkg::MARGIN_W);
  localparam int DW       = $clog2(DIM_TOP + 1);
  localparam int PROD_W   = SB + bs3_pkg::COEF_W;
  localparam int PART_W   = PROD_W + 2;
  localparam int SUM_W    = PROD_W + 4;
  localparam int SH_W     = SUM_W - bs3_pkg::FRAC_W;
  localparam int CW       = bs3_pkg::COEF_W;

  // ---------------- configuration registers ----------------
  logic [bs3_pkg::COEF_ROW_W-1:0] coef_r [3];
  logic [bs3_pkg::FRAME_W-1:0]    width_r;
  logic [bs3_pkg::FRAME_W-1:0]    height_r;
  logic [bs3_pkg::MARGIN_W-1:0]   margin_r;
  bs3_pkg::reg_idx_t              reg_idx;
  logic                           cfg_wr;

  assign reg_idx = bs3_pkg::reg_idx_t'(paddr[bs3_pkg::ADDR_W-1:3]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= bs3_pkg::COEF_TOP_RST;
      coef_r[1] <= bs3_pkg::COEF_MID_RST;
      coef_r[2] <= bs3_pkg::COEF_BOTTOM_RST;
      width_r   <= bs3_pkg::FRAME_WIDTH_RST;
      height_r  <= bs3_pkg::FRAME_HEIGHT_RST;
      margin_r  <= bs3_pkg::MARGIN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bs3_pkg::REG_COEF_TOP:     coef_r[0] <= pwdata[bs3_pkg::COEF_ROW_W-1:0];
        bs3_pkg::REG_COEF_MID:     coef_r[1] <= pwdata[bs3_pkg::COEF_ROW_W-1:0];
        bs3_pkg::REG_COEF_BOTTOM:  coef_r[2] <= pwdata[bs3_pkg::COEF_ROW_W-1:0];
        bs3_pkg::REG_FRAME_WIDTH:  width_r   <= pwdata[bs3_pkg::FRAME_W-1:0];
        bs3_pkg::REG_FRAME_HEIGHT: height_r  <= pwdata[bs3_pkg::FRAME_W-1:0];
        bs3_pkg::REG_MARGIN:       margin_r  <= pwdata[bs3_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bs3_pkg::REG_COEF_TOP:     prdata = bs3_pkg::DATA_W'(coef_r[0]);
      bs3_pkg::REG_COEF_MID:     prdata = bs3_pkg::DATA_W'(coef_r[1]);
      bs3_pkg::REG_COEF_BOTTOM:  prdata = bs3_pkg::DATA_W'(coef_r[2]);
      bs3_pkg::REG_FRAME_WIDTH:  prdata = bs3_pkg::DATA_W'(width_r);
      bs3_pkg::REG_FRAME_HEIGHT: prdata = bs3_pkg::DATA_W'(height_r);
      bs3_pkg::REG_MARGIN:       prdata = bs3_pkg::DATA_W'(margin_r);
      default:                   prdata = '0;
    endcase
  end

  // effective geometry: clamp width/height, margin of zero acts as one
  logic [DW-1:0]                w_eff;
  logic [DW-1:0]                h_eff;
  logic [bs3_pkg::MARGIN_W-1:0] m_eff;
  logic [DW-1:0]                m_ext;

  always_comb begin
    if (DW'(width_r) < DW'(3)) begin
      w_eff = DW'(3);
    end else if (DW'(width_r) > DW'(MAX_WIDTH)) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = DW'(width_r);
    end
    if (DW'(height_r) < DW'(3)) begin
      h_eff = DW'(3);
    end else if (DW'(height_r) > DW'(MAX_HEIGHT)) begin
      h_eff = DW'(MAX_HEIGHT);
    end else begin
      h_eff = DW'(height_r);
    end
    m_eff = (margin_r == '0) ? bs3_pkg::MARGIN_W'(1) : margin_r;
  end

  assign m_ext = DW'(m_eff);

  // ---------------- pipeline control ----------------
  logic en;
  logic accept;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && en;

  // ---------------- raster position ----------------
  logic [DW-1:0] col_pos_r, row_pos_r;
  logic [DW-1:0] col_cur, row_cur;
  logic [DW-1:0] col_pos_nxt;

  always_comb begin
    col_cur = col_pos_r;
    row_cur = row_pos_r;
    if (in_frame_start) begin
      col_cur = '0;
      row_cur = '0;
    end
    if (col_cur >= w_eff) begin
      col_cur = '0;
      row_cur = row_cur + DW'(1);
    end
    if (row_cur >= h_eff) begin
      row_cur = '0;
    end
    col_pos_nxt = col_cur + DW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (accept) begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_cur;
    end
  end

  // ---------------- stage 1: line store read returns ----------------
  logic                 s1_valid_r;
  logic signed [SB-1:0] s1_sample_r;
  logic [COL_W-1:0]     s1_col_r;
  logic [ROW_W-1:0]     s1_row_r;
  logic                 s1_byp_r;
  logic signed [SB-1:0] byp_near_r, byp_far_r;
  logic [SB-1:0]        near_rdata, far_rdata;
  logic signed [SB-1:0] top_v, mid_v;
  logic                 ls_we;
  logic [COL_W-1:0]     rd_addr;

  assign rd_addr = col_cur[COL_W-1:0];
  assign ls_we   = en && s1_valid_r;

  // same-edge write and read of one column: forward the write data
  assign top_v = s1_byp_r ? byp_far_r  : $signed(far_rdata);
  assign mid_v = s1_byp_r ? byp_near_r : $signed(near_rdata);

  bs3_ram #(.WIDTH(SB), .DEPTH(MAX_WIDTH)) u_near (
    .clk   (clk),
    .we    (ls_we),
    .waddr (s1_col_r),
    .wdata (s1_sample_r),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (near_rdata)
  );

  bs3_ram #(.WIDTH(SB), .DEPTH(MAX_WIDTH)) u_far (
    .clk   (clk),
    .we    (ls_we),
    .waddr (s1_col_r),
    .wdata (mid_v),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (far_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r <= in_sample;
      s1_col_r    <= col_cur[COL_W-1:0];
      s1_row_r    <= row_cur[ROW_W-1:0];
      s1_byp_r    <= ls_we && (s1_col_r == rd_addr);
      byp_near_r  <= s1_sample_r;
      byp_far_r   <= mid_v;
    end
  end

  // window: [0..2] previous column (top, mid, bottom), [3..5] the one before
  logic signed [SB-1:0] win_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 6; k++) begin
        win_r[k] <= '0;
      end
    end else if (ls_we) begin
      win_r[3] <= win_r[0];
      win_r[4] <= win_r[1];
      win_r[5] <= win_r[2];
      win_r[0] <= top_v;
      win_r[1] <= mid_v;
      win_r[2] <= s1_sample_r;
    end
  end

  // nine products: column j (left, centre, right) times row i (top, mid, bottom)
  logic signed [SB-1:0]     taps [3][3];
  logic signed [CW-1:0]     wts  [3][3];
  logic signed [PROD_W-1:0] prod_nxt [9];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      taps[0][i] = win_r[3 + i];
      taps[1][i] = win_r[i];
      wts[0][i]  = $signed(coef_r[i][bs3_pkg::SLOT_LEFT * CW +: CW]);
      wts[1][i]  = $signed(coef_r[i][bs3_pkg::SLOT_CENTRE * CW +: CW]);
      wts[2][i]  = $signed(coef_r[i][bs3_pkg::SLOT_RIGHT * CW +: CW]);
    end
    taps[2][0] = top_v;
    taps[2][1] = mid_v;
    taps[2][2] = s1_sample_r;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        prod_nxt[j * 3 + i] = PROD_W'(taps[j][i]) * PROD_W'(wts[j][i]);
      end
    end
  end

  // emit only centres at least the margin away from every edge
  logic [DW-1:0] r_ext, c_ext, cr, cc;
  logic          emit_nxt, end_nxt;

  always_comb begin
    r_ext    = DW'(s1_row_r);
    c_ext    = DW'(s1_col_r);
    cr       = r_ext - DW'(1);
    cc       = c_ext - DW'(1);
    emit_nxt = s1_valid_r && (r_ext >= DW'(2)) && (c_ext >= DW'(2))
               && (cr >= m_ext) && (cc >= m_ext)
               && ((cr + m_ext) < h_eff) && ((cc + m_ext) < w_eff);
    end_nxt  = ((cr + m_ext + DW'(1)) == h_eff) && ((cc + m_ext + DW'(1)) == w_eff);
  end

  // ---------------- stage 2: products ----------------
  logic                     s2_valid_r;
  logic signed [PROD_W-1:0] s2_prod_r [9];
  logic [ROW_W-1:0]         s2_row_r;
  logic [COL_W-1:0]         s2_col_r;
  logic                     s2_end_r;

  // ---------------- stage 3: three partial sums ----------------
  logic                     s3_valid_r;
  logic signed [PART_W-1:0] s3_part_r [3];
  logic [ROW_W-1:0]         s3_row_r;
  logic [COL_W-1:0]         s3_col_r;
  logic                     s3_end_r;

  // ---------------- stage 4: full sum ----------------
  logic                     s4_valid_r;
  logic signed [SUM_W-1:0]  s4_sum_r;
  logic [ROW_W-1:0]         s4_row_r;
  logic [COL_W-1:0]         s4_col_r;
  logic                     s4_end_r;

  logic signed [PART_W-1:0] part_nxt [3];
  logic signed [SUM_W-1:0]  sum_nxt;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      part_nxt[j] = PART_W'(s2_prod_r[j * 3]) + PART_W'(s2_prod_r[j * 3 + 1])
                    + PART_W'(s2_prod_r[j * 3 + 2]);
    end
    sum_nxt = SUM_W'(s3_part_r[0]) + SUM_W'(s3_part_r[1]) + SUM_W'(s3_part_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= emit_nxt;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        s2_prod_r[k] <= prod_nxt[k];
      end
      s2_row_r <= cr[ROW_W-1:0];
      s2_col_r <= cc[COL_W-1:0];
      s2_end_r <= end_nxt;
      for (int j = 0; j < 3; j++) begin
        s3_part_r[j] <= part_nxt[j];
      end
      s3_row_r <= s2_row_r;
      s3_col_r <= s2_col_r;
      s3_end_r <= s2_end_r;
      s4_sum_r <= sum_nxt;
      s4_row_r <= s3_row_r;
      s4_col_r <= s3_col_r;
      s4_end_r <= s3_end_r;
    end
  end

  // ---------------- floor shift, saturate, output word ----------------
  logic [SH_W-1:0]      shifted;
  logic [SH_W-SB:0]     upper;
  logic                 sat_nxt;
  logic signed [SB-1:0] value_nxt;

  always_comb begin
    shifted = s4_sum_r[SUM_W-1:bs3_pkg::FRAC_W];   // arithmetic shift = floor
    upper   = shifted[SH_W-1:SB-1];
    sat_nxt = !((&upper) || !(|upper));
    if (sat_nxt) begin
      value_nxt = shifted[SH_W-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    end else begin
      value_nxt = $signed(shifted[SB-1:0]);
    end
  end

  logic                 out_valid_r;
  logic signed [SB-1:0] out_value_r;
  logic [ROW_W-1:0]     out_row_r;
  logic [COL_W-1:0]     out_col_r;
  logic                 out_end_r;
  logic                 out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s4_valid_r) begin
      out_value_r <= value_nxt;
      out_row_r   <= s4_row_r;
      out_col_r   <= s4_col_r;
      out_end_r   <= s4_end_r;
      out_sat_r   <= sat_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_stencil_value = out_value_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_frame_end     = out_end_r;
  assign out_saturated     = out_sat_r;

endmodule

// ===== rtl/bs3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bs3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== dv/tb_box_stencil_3x3.sv =====
// Self-checking testbench for box_stencil_3x3: directed, clamp, stall and random grid runs.
module tb_box_stencil_3x3;

  localparam int MAX_W    = 1024;
  localparam int MAX_H    = 1024;
  localparam int SAMPLE_W = 32;
  localparam int ROW_W    = $clog2(MAX_H);
  localparam int COL_W    = $clog2(MAX_W);
  localparam int LIMIT    = 500000;
  localparam int SETTLE   = 12;        // slack beyond the pipe depth
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  localparam int COEF_W     = bs3_pkg::COEF_W;
  localparam int COEF_ROW_W = bs3_pkg::COEF_ROW_W;
  localparam int FRAME_W    = bs3_pkg::FRAME_W;
  localparam int MARGIN_W   = bs3_pkg::MARGIN_W;
  localparam int ADDR_W     = bs3_pkg::ADDR_W;
  localparam int DATA_W     = bs3_pkg::DATA_W;
  localparam int FRAC_W     = bs3_pkg::FRAC_W;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic [ROW_W-1:0]           row;
    logic [COL_W-1:0]           col;
    logic                       last;
    logic                       sat;
  } stencil_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_stencil_value;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic out_frame_end;
  logic out_saturated;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  box_stencil_3x3 #(
    .MAX_WIDTH(MAX_W),
    .MAX_HEIGHT(MAX_H),
    .SAMPLE_BITS(SAMPLE_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_sample(in_sample),
    .in_frame_start(in_frame_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_stencil_value(out_stencil_value),
    .out_row(out_row),
    .out_col(out_col),
    .out_frame_end(out_frame_end),
    .out_saturated(out_saturated),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // register copies and grid state of the predictor
  logic [COEF_ROW_W-1:0] coef_rows [3];
  logic [FRAME_W-1:0] width_reg;
  logic [FRAME_W-1:0] height_reg;
  logic [MARGIN_W-1:0] margin_reg;
  logic signed [SAMPLE_W-1:0] near_line [MAX_W];
  logic signed [SAMPLE_W-1:0] far_line [MAX_W];
  logic signed [SAMPLE_W-1:0] win [6];
  int row_pos = 0;
  int col_pos = 0;

  stencil_point_t pending_points[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int words_sent = 0;
  int points_checked = 0;
  int clipped_seen = 0;
  int frame_ends_seen = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles, %0d points still pending", LIMIT,
               pending_points.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int clamp_size(input logic [FRAME_W-1:0] v, input int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // one input word through the predictor; queues the point it completes, if any
  function automatic void predict_stencil(input logic signed [SAMPLE_W-1:0] s,
                                          input logic fs);
    int w, h, m, r, c, cr, cc;
    int slot_of [3];
    logic signed [SAMPLE_W-1:0] top_v, mid_v;
    logic signed [SAMPLE_W-1:0] cols [3][3];
    logic signed [COEF_W-1:0] k;
    longint acc, v;
    stencil_point_t p;
    slot_of[0] = bs3_pkg::SLOT_LEFT;
    slot_of[1] = bs3_pkg::SLOT_CENTRE;
    slot_of[2] = bs3_pkg::SLOT_RIGHT;
    w = clamp_size(width_reg, MAX_W);
    h = clamp_size(height_reg, MAX_H);
    m = (margin_reg == 0) ? 1 : int'(margin_reg);
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    top_v = far_line[c];
    mid_v = near_line[c];
    if (r >= 2 && c >= 2) begin
      cr = r - 1;
      cc = c - 1;
      if (cr >= m && cc >= m && cr + m < h && cc + m < w) begin
        for (int i = 0; i < 3; i++) begin
          cols[0][i] = win[3 + i];
          cols[1][i] = win[i];
        end
        cols[2][0] = top_v;
        cols[2][1] = mid_v;
        cols[2][2] = s;
        acc = 0;
        for (int j = 0; j < 3; j++) begin
          for (int i = 0; i < 3; i++) begin
            k = coef_rows[i][slot_of[j]*COEF_W +: COEF_W];
            acc += longint'(cols[j][i]) * longint'(k);
          end
        end
        v = acc >>> FRAC_W;   // arithmetic shift floors
        p.sat = 1'b0;
        if (v > SAT_HI) begin
          v = SAT_HI;
          p.sat = 1'b1;
        end
        if (v < SAT_LO) begin
          v = SAT_LO;
          p.sat = 1'b1;
        end
        p.value = v[SAMPLE_W-1:0];
        p.row = ROW_W'(cr);
        p.col = COL_W'(cc);
        p.last = (cr + m + 1 == h) && (cc + m + 1 == w);
        pending_points.push_back(p);
      end
    end
    win[3] = win[0];
    win[4] = win[1];
    win[5] = win[2];
    win[0] = top_v;
    win[1] = mid_v;
    win[2] = s;
    far_line[c] = mid_v;
    near_line[c] = s;
    col_pos = c + 1;
    row_pos = r;
  endfunction

  task automatic check_point();
    stencil_point_t e;
    if (pending_points.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: result at row %0d col %0d with nothing pending", out_row, out_col);
      return;
    end
    e = pending_points.pop_front();
    if (out_stencil_value !== e.value || out_row !== e.row || out_col !== e.col ||
        out_frame_end !== e.last || out_saturated !== e.sat) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: expected val %0d row %0d col %0d end %0b sat %0b, ",
                  "got %0d %0d %0d %0b %0b"},
                 e.value, e.row, e.col, e.last, e.sat,
                 out_stencil_value, out_row, out_col, out_frame_end, out_saturated);
    end else begin
      points_checked++;
      if (e.sat) clipped_seen++;
      if (e.last) frame_ends_seen++;
    end
  endtask

  // result side: random stalls, long hold-offs on request, checking
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_point();
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(input bs3_pkg::reg_idx_t idx, input logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      bs3_pkg::REG_COEF_TOP:     coef_rows[0] = val[COEF_ROW_W-1:0];
      bs3_pkg::REG_COEF_MID:     coef_rows[1] = val[COEF_ROW_W-1:0];
      bs3_pkg::REG_COEF_BOTTOM:  coef_rows[2] = val[COEF_ROW_W-1:0];
      bs3_pkg::REG_FRAME_WIDTH:  width_reg = val[FRAME_W-1:0];
      bs3_pkg::REG_FRAME_HEIGHT: height_reg = val[FRAME_W-1:0];
      bs3_pkg::REG_MARGIN:       margin_reg = val[MARGIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_word(input logic [SAMPLE_W-1:0] s, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    predict_stencil(s, fs);
    words_sent++;
  endtask

  task automatic wait_points_out();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  // words that complete no point may still be in the pipe after the last result
  task automatic drain_results();
    wait_points_out();
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [COEF_W-1:0] rand_weight();
    case ($urandom_range(5))
      0: return COEF_W'($urandom());
      1: return 18'h1FFFF;
      2: return 18'h20000;
      3: return '0;
      4: return 18'h10000;
      default: return COEF_W'($urandom_range(32768) - 16384);
    endcase
  endfunction

  function automatic logic [COEF_ROW_W-1:0] pack_weights(input logic [COEF_W-1:0] left,
                                                         input logic [COEF_W-1:0] centre,
                                                         input logic [COEF_W-1:0] right);
    logic [COEF_ROW_W-1:0] row;
    row = '0;
    row[bs3_pkg::SLOT_LEFT*COEF_W +: COEF_W] = left;
    row[bs3_pkg::SLOT_CENTRE*COEF_W +: COEF_W] = centre;
    row[bs3_pkg::SLOT_RIGHT*COEF_W +: COEF_W] = right;
    return row;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 32'h7FFFFFFF;
          1: return 32'h80000000;
          2: return 32'h0;
          default: return 32'hFFFFFFFF;
        endcase
      end
      1, 2, 3: return SAMPLE_W'($urandom_range(32'h200000) - 32'h100000);
      default: return $urandom();
    endcase
  endfunction

  // sometimes set bits above the register width; they must be dropped
  function automatic logic [DATA_W-1:0] with_noise(input logic [DATA_W-1:0] field,
                                                   input int bits);
    logic [DATA_W-1:0] mask;
    mask = (64'd1 << bits) - 64'd1;
    if ($urandom_range(3) == 0) return ({$urandom(), $urandom()} & ~mask) | (field & mask);
    return field & mask;
  endfunction

  task automatic send_grid_run(input int n, input bit fresh, input int restart_pct);
    for (int i = 0; i < n; i++)
      send_word(rand_sample(), (i == 0 && fresh) || ($urandom_range(99) < restart_pct));
  endtask

  task automatic randomize_weights();
    write_reg(bs3_pkg::REG_COEF_TOP,
              pack_weights(rand_weight(), rand_weight(), rand_weight()));
    write_reg(bs3_pkg::REG_COEF_MID,
              pack_weights(rand_weight(), rand_weight(), rand_weight()));
    write_reg(bs3_pkg::REG_COEF_BOTTOM,
              pack_weights(rand_weight(), rand_weight(), rand_weight()));
  endtask

  // smallest legal grid (reached through clamped sizes and a zero margin), full-scale words
  task automatic test_saturation_extremes();
    write_reg(bs3_pkg::REG_FRAME_WIDTH, 64'd0);
    write_reg(bs3_pkg::REG_FRAME_HEIGHT, 64'd1);
    write_reg(bs3_pkg::REG_MARGIN, 64'd0);
    write_reg(bs3_pkg::REG_COEF_TOP, pack_weights(18'h1FFFF, 18'h1FFFF, 18'h1FFFF));
    write_reg(bs3_pkg::REG_COEF_MID, pack_weights(18'h1FFFF, 18'h1FFFF, 18'h1FFFF));
    write_reg(bs3_pkg::REG_COEF_BOTTOM, pack_weights(18'h1FFFF, 18'h1FFFF, 18'h1FFFF));
    for (int i = 0; i < 9; i++) send_word(32'h7FFFFFFF, i == 0);
    for (int i = 0; i < 9; i++) send_word(32'h80000000, i == 0);
    drain_results();
  endtask

  // margin beyond the grid: nothing may come out
  task automatic test_margin_too_large();
    write_reg(bs3_pkg::REG_FRAME_WIDTH, 64'd3);
    write_reg(bs3_pkg::REG_FRAME_HEIGHT, 64'd3);
    write_reg(bs3_pkg::REG_MARGIN, 64'd511);
    for (int i = 0; i < 9; i++) send_word(rand_sample(), i == 0);
    drain_results();
  endtask

  // oversize width and height clamp to the line store depth: a short run stays in row 0
  task automatic test_size_clamp();
    randomize_weights();
    write_reg(bs3_pkg::REG_MARGIN, 64'd1);
    write_reg(bs3_pkg::REG_FRAME_WIDTH, 64'd2047);
    write_reg(bs3_pkg::REG_FRAME_HEIGHT, 64'd2047);
    send_grid_run(24, 1'b1, 0);
    drain_results();
  endtask

  task automatic test_backpressure();
    int saved_idle;
    saved_idle = send_idle_pct;
    send_idle_pct = 0;
    write_reg(bs3_pkg::REG_FRAME_WIDTH, 64'd6);
    write_reg(bs3_pkg::REG_FRAME_HEIGHT, 64'd5);
    write_reg(bs3_pkg::REG_MARGIN, 64'd1);
    randomize_weights();
    hold_left = 200;
    send_grid_run(60, 1'b1, 0);
    // sender stops until the block is empty, then carries on in the same grid
    wait_points_out();
    send_grid_run(40, 1'b0, 0);
    drain_results();
    send_idle_pct = saved_idle;
  endtask

  task automatic random_phase();
    int old_w, w, h, n, sel;
    bit fresh;
    old_w = clamp_size(width_reg, MAX_W);
    if ($urandom_range(1)) randomize_weights();
    if ($urandom_range(2) != 0) begin
      sel = $urandom_range(99);
      if (sel < 80) w = $urandom_range(3, 12);
      else if (sel < 95) w = $urandom_range(13, 48);
      else w = $urandom_range(0, 2);
      write_reg(bs3_pkg::REG_FRAME_WIDTH, with_noise(64'(w), FRAME_W));
    end
    if ($urandom_range(2) != 0) begin
      sel = $urandom_range(99);
      if (sel < 85) h = $urandom_range(3, 8);
      else if (sel < 95) h = $urandom_range(9, 20);
      else if (sel < 98) h = $urandom_range(0, 2);
      else h = $urandom_range(1025, 2047);
      write_reg(bs3_pkg::REG_FRAME_HEIGHT, with_noise(64'(h), FRAME_W));
    end
    if ($urandom_range(2) != 0) begin
      sel = $urandom_range(99);
      if (sel < 75)
        write_reg(bs3_pkg::REG_MARGIN, with_noise(64'($urandom_range(1, 3)), MARGIN_W));
      else if (sel < 85)
        write_reg(bs3_pkg::REG_MARGIN, with_noise(64'd0, MARGIN_W));
      else if (sel < 92)
        write_reg(bs3_pkg::REG_MARGIN, with_noise(64'($urandom_range(4, 6)), MARGIN_W));
      else
        write_reg(bs3_pkg::REG_MARGIN, with_noise(64'($urandom_range(200, 511)), MARGIN_W));
    end
    w = clamp_size(width_reg, MAX_W);
    h = clamp_size(height_reg, MAX_H);
    // carrying on mid-grid is only safe when the rows did not get wider
    fresh = !(w <= old_w && $urandom_range(3) == 0);
    n = w * h * $urandom_range(1, 2) + $urandom_range(0, 2 * w);
    if (n > 160) n = 160;
    send_grid_run(n, fresh, 2);
    drain_results();
  endtask

  task automatic test_random_grids(input int n_words);
    int start;
    start = words_sent;
    while (words_sent - start < n_words) random_phase();
  endtask

  initial begin
    coef_rows[0] = bs3_pkg::COEF_TOP_RST;
    coef_rows[1] = bs3_pkg::COEF_MID_RST;
    coef_rows[2] = bs3_pkg::COEF_BOTTOM_RST;
    width_reg = bs3_pkg::FRAME_WIDTH_RST;
    height_reg = bs3_pkg::FRAME_HEIGHT_RST;
    margin_reg = bs3_pkg::MARGIN_RST;
    for (int i = 0; i < MAX_W; i++) begin
      near_line[i] = '0;
      far_line[i] = '0;
    end
    for (int i = 0; i < 6; i++) win[i] = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 17;
    recv_idle_pct = 45;
    test_saturation_extremes();
    test_margin_too_large();
    test_size_clamp();
    test_random_grids(60);

    send_idle_pct = 45;
    recv_idle_pct = 17;
    test_backpressure();
    test_random_grids(60);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_grids(60);

    drain_results();
    $display("run: %0d words in, %0d points checked, %0d clipped, %0d grid ends",
             words_sent, points_checked, clipped_seen, frame_ends_seen);
    $display("grids from 3x3 up to oversize clamped sizes, margins 0..511, stalls on both sides");
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d points never seen", mismatches, pending_points.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
